[hw/rtl/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the module status state machine
// State codes, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned TimeW  = 16;
  localparam int unsigned StateW = 3;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW = 2;

  // state / LED effect codes
  localparam logic [StateW-1:0] ST_BOOT        = 3'd0;
  localparam logic [StateW-1:0] ST_NORMAL      = 3'd1;
  localparam logic [StateW-1:0] ST_HIT         = 3'd2;
  localparam logic [StateW-1:0] ST_FAULT       = 3'd3;
  localparam logic [StateW-1:0] ST_LINK_DOWN   = 3'd4;
  localparam logic [StateW-1:0] ST_ID_SETUP    = 3'd5;
  localparam logic [StateW-1:0] ST_ID_CONFLICT = 3'd6;

  // command codes
  localparam logic [CmdW-1:0] CMD_TICK = 2'd0;
  localparam logic [CmdW-1:0] CMD_COMM = 2'd1;
  localparam logic [CmdW-1:0] CMD_ID   = 2'd2;
  localparam logic [CmdW-1:0] CMD_HIT  = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BOOT_TIME = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HIT_TIME  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ID_SHOW   = 2'd2;

  localparam logic [TimeW-1:0] BOOT_TIME_RST = 16'd300;
  localparam logic [TimeW-1:0] HIT_TIME_RST  = 16'd300;
  localparam logic [TimeW-1:0] ID_SHOW_RST   = 16'd1000;
  localparam logic [TimeW-1:0] DWELL_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [TimeW-1:0] boot_time_ms;
    logic [TimeW-1:0] hit_time_ms;
    logic [TimeW-1:0] id_show_ms;
  } cfg_t;

  typedef struct packed {
    logic [StateW-1:0] mode;
    logic [TimeW-1:0]  dwell;
    logic              link_lost;
    logic              effect_set;
    logic [StateW-1:0] effect;
  } step_t;

endpackage

[hw/rtl/mss_cfg.sv]
// ----------------------------------------------------------------------------
// mss_cfg: configuration register file
// Holds the three time-out registers, written through the cfg channel.
// ----------------------------------------------------------------------------
module mss_cfg import mss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [TimeW-1:0]   wr_data,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_BOOT_TIME: cfg_nxt.boot_time_ms = wr_data;
        REG_HIT_TIME:  cfg_nxt.hit_time_ms  = wr_data;
        REG_ID_SHOW:   cfg_nxt.id_show_ms   = wr_data;
        default:       cfg_nxt = cfg_r;  // index beyond the list: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.boot_time_ms <= BOOT_TIME_RST;
      cfg_r.hit_time_ms  <= HIT_TIME_RST;
      cfg_r.id_show_ms   <= ID_SHOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/mss_step.sv]
// ----------------------------------------------------------------------------
// mss_step: next-state logic for one beat
// Computes mode, dwell count, link-lost latch and LED effect from one command.
// ----------------------------------------------------------------------------
module mss_step import mss_pkg::*; (
  input  logic [StateW-1:0] mode,
  input  logic [TimeW-1:0]  dwell,
  input  logic              link_lost,
  input  cfg_t              cfg,
  input  logic [CmdW-1:0]   cmd,
  input  logic              flag,
  input  logic              fault_present,
  output step_t             step
);

  logic              enter_en;
  logic [StateW-1:0] enter_st;
  logic [TimeW-1:0]  dwell_inc;
  logic [TimeW-1:0]  dwell_hold;
  logic              latch_nxt;

  assign dwell_inc = (dwell == DWELL_MAX) ? dwell : dwell + 16'd1;

  always_comb begin
    enter_en   = 1'b0;
    enter_st   = ST_NORMAL;
    dwell_hold = dwell;
    latch_nxt  = link_lost;
    unique case (cmd)
      CMD_TICK: begin
        dwell_hold = dwell_inc;
        if (fault_present) begin
          if (mode != ST_FAULT) begin
            enter_en = 1'b1;
            enter_st = ST_FAULT;
          end
        end else if (link_lost) begin
          if (mode != ST_LINK_DOWN) begin
            enter_en = 1'b1;
            enter_st = ST_LINK_DOWN;
          end
        end else begin
          // time out to normal; fault clears at once
          unique case (mode)
            ST_BOOT:        enter_en = (dwell_inc >= cfg.boot_time_ms);
            ST_HIT:         enter_en = (dwell_inc >= cfg.hit_time_ms);
            ST_FAULT:       enter_en = 1'b1;
            ST_ID_SETUP,
            ST_ID_CONFLICT: enter_en = (dwell_inc >= cfg.id_show_ms);
            default:        enter_en = 1'b0;
          endcase
        end
      end
      CMD_COMM: begin
        latch_nxt = flag;
        if (flag) begin
          enter_en = (mode != ST_FAULT);
          enter_st = ST_LINK_DOWN;
        end else begin
          enter_en = (mode == ST_LINK_DOWN);
        end
      end
      CMD_ID: begin
        enter_en = 1'b1;
        enter_st = flag ? ST_ID_CONFLICT : ST_ID_SETUP;
      end
      default: begin
        enter_en = (mode == ST_NORMAL) || (mode == ST_HIT);
        enter_st = ST_HIT;
      end
    endcase

    step.link_lost  = latch_nxt;
    step.effect_set = enter_en;
    step.mode       = enter_en ? enter_st : mode;
    step.dwell      = enter_en ? '0 : dwell_hold;
    step.effect     = enter_en ? enter_st : '0;
  end

endmodule

[hw/rtl/module_status_state_machine_core.sv]
// ----------------------------------------------------------------------------
// module_status_state_machine_core: status LED state controller
// Input register, single-pass next-state logic, result register.
// ----------------------------------------------------------------------------
// Path: an input beat goes through the input register, then the result register.
// Throughput: one beat per cycle unless the result side stalls.
// Reset: synchronous; mode boot, dwell 0, link-lost latch clear, time-outs
// 300/300/1000, both pipeline registers empty. No result is produced by reset.
module module_status_state_machine_core import mss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CmdW-1:0]    in_cmd,
  input  logic               in_flag,
  input  logic               in_fault_present,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [StateW-1:0]  out_state,
  output logic               out_effect_set,
  output logic [StateW-1:0]  out_effect,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_data
);

  cfg_t cfg;

  logic              in_v_r;
  logic [CmdW-1:0]   cmd_r;
  logic              flag_r;
  logic              fault_r;
  logic              out_v_r;
  logic [StateW-1:0] out_state_r;
  logic              out_fx_set_r;
  logic [StateW-1:0] out_fx_r;
  logic [StateW-1:0] mode_r;
  logic [TimeW-1:0]  dwell_r;
  logic              latch_r;
  logic              adv;
  step_t             step;

  assign cfg_ready = 1'b1;

  mss_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mss_step u_step (
    .mode          (mode_r),
    .dwell         (dwell_r),
    .link_lost     (latch_r),
    .cfg           (cfg),
    .cmd           (cmd_r),
    .flag          (flag_r),
    .fault_present (fault_r),
    .step          (step)
  );

  // advance the held beat when the result register is free or being drained
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      mode_r  <= ST_BOOT;
      dwell_r <= '0;
      latch_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        mode_r  <= step.mode;
        dwell_r <= step.dwell;
        latch_r <= step.link_lost;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r   <= in_cmd;
      flag_r  <= in_flag;
      fault_r <= in_fault_present;
    end
    if (adv) begin
      out_state_r  <= step.mode;
      out_fx_set_r <= step.effect_set;
      out_fx_r     <= step.effect;
    end
  end

  assign out_valid      = out_v_r;
  assign out_state      = out_state_r;
  assign out_effect_set = out_fx_set_r;
  assign out_effect     = out_fx_r;

`ifndef SYNTHESIS
  a_effect_is_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_fx_set_r |-> out_fx_r == out_state_r)
    else $error("effect code differs from the state entered");

  a_enter_clears_dwell: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step.effect_set |=> dwell_r == '0)
    else $error("dwell count not cleared on state entry");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_v_r && !out_v_r)
    else $error("pipeline not empty after reset");

  a_state_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_state_r == mode_r)
    else $error("reported state differs from held mode");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: module status state machine core
// Sends commands (ticks, link events, ID events, hits) and configuration
// writes, predicts state and LED effect per beat, and checks every result
// beat in order. A directed table comes first, then a short run at the
// maximum time-outs, then random phases under varying handshake pressure.
// ----------------------------------------------------------------------------
module testbench;
  import mss_pkg::*;

  localparam logic [StateW-1:0] NO_FX = 3'd0;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 180;
  localparam int SRC_IDLE [4] = '{0, 80, 0, 22};
  localparam int SINK_STALL [4] = '{0, 0, 80, 22};

  typedef struct packed {
    logic [StateW-1:0] state;
    logic              effect_set;
    logic [StateW-1:0] effect;
  } status_t;

  localparam status_t NO_STATUS = '0;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [TimeW-1:0]   data;
    logic [CmdW-1:0]    cmd;
    logic               flag;
    logic               fault;
    logic               typed;
    status_t            exp;
  } dir_row_t;

  // cfg, index, data, cmd, flag, fault, typed, expected
  localparam dir_row_t DIRECTED [25] = '{
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b0, 1'b1, '{ST_BOOT, 1'b0, NO_FX}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_HIT,  1'b1, 1'b1, 1'b1, '{ST_BOOT, 1'b0, NO_FX}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_COMM, 1'b0, 1'b1, 1'b1, '{ST_BOOT, 1'b0, NO_FX}},
    '{1'b1, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b1, 1'b0, 1'b1,
      '{ST_NORMAL, 1'b1, ST_NORMAL}},
    '{1'b1, REG_HIT_TIME,  16'd0, CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_HIT,  1'b1, 1'b0, 1'b1, '{ST_HIT, 1'b1, ST_HIT}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b1, REG_ID_SHOW,   16'd0, CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_ID,   1'b1, 1'b1, 1'b1,
      '{ST_ID_CONFLICT, 1'b1, ST_ID_CONFLICT}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b1, 1'b1, '{ST_FAULT, 1'b1, ST_FAULT}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b1, 1'b1, 1'b1, '{ST_FAULT, 1'b0, NO_FX}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_COMM, 1'b1, 1'b0, 1'b1, '{ST_FAULT, 1'b0, NO_FX}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_HIT,  1'b0, 1'b0, 1'b1, '{ST_FAULT, 1'b0, NO_FX}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b0, 1'b1,
      '{ST_LINK_DOWN, 1'b1, ST_LINK_DOWN}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_COMM, 1'b1, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_ID,   1'b0, 1'b0, 1'b1,
      '{ST_ID_SETUP, 1'b1, ST_ID_SETUP}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_COMM, 1'b0, 1'b0, 1'b1,
      '{ST_NORMAL, 1'b1, ST_NORMAL}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_COMM, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_COMM, 1'b1, 1'b1, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b1, 1'b1, '{ST_FAULT, 1'b1, ST_FAULT}},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_COMM, 1'b0, 1'b0, 1'b0, NO_STATUS},
    '{1'b0, REG_BOOT_TIME, 16'd0, CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CmdW-1:0]    in_cmd = CMD_TICK;
  logic               in_flag = 1'b0;
  logic               in_fault_present = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StateW-1:0]  out_state;
  logic               out_effect_set;
  logic [StateW-1:0]  out_effect;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = REG_BOOT_TIME;
  logic [TimeW-1:0]   cfg_data = '0;

  // typed expectation that travels with the input beat
  logic    in_typed = 1'b0;
  status_t in_exp = NO_STATUS;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // predicted block state and time-outs
  logic [StateW-1:0] pm_mode;
  logic [TimeW-1:0]  pm_dwell;
  logic              pm_link_lost;
  logic              pm_fx_set;
  logic [StateW-1:0] pm_fx;
  logic [TimeW-1:0]  tm_boot;
  logic [TimeW-1:0]  tm_hit;
  logic [TimeW-1:0]  tm_id;

  status_t pending_status [$];

  module_status_state_machine_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_flag          (in_flag),
    .in_fault_present (in_fault_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_state        (out_state),
    .out_effect_set   (out_effect_set),
    .out_effect       (out_effect),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void enter_mode(logic [StateW-1:0] s);
    pm_mode = s;
    pm_dwell = '0;
    pm_fx_set = 1'b1;
    pm_fx = s;
  endfunction

  function automatic status_t next_status(logic [CmdW-1:0] cmd, logic flag, logic fault);
    status_t res;
    pm_fx_set = 1'b0;
    pm_fx = NO_FX;
    case (cmd)
      CMD_TICK: begin
        if (pm_dwell != DWELL_MAX) pm_dwell = pm_dwell + 1'b1;
        if (fault) begin
          if (pm_mode != ST_FAULT) enter_mode(ST_FAULT);
        end else if (pm_link_lost) begin
          if (pm_mode != ST_LINK_DOWN) enter_mode(ST_LINK_DOWN);
        end else begin
          case (pm_mode)
            ST_BOOT: if (pm_dwell >= tm_boot) enter_mode(ST_NORMAL);
            ST_HIT: if (pm_dwell >= tm_hit) enter_mode(ST_NORMAL);
            ST_FAULT: enter_mode(ST_NORMAL);
            ST_ID_SETUP, ST_ID_CONFLICT: if (pm_dwell >= tm_id) enter_mode(ST_NORMAL);
            default: ;
          endcase
        end
      end
      CMD_COMM: begin
        pm_link_lost = flag;
        if (flag) begin
          if (pm_mode != ST_FAULT) enter_mode(ST_LINK_DOWN);
        end else if (pm_mode == ST_LINK_DOWN) begin
          enter_mode(ST_NORMAL);
        end
      end
      CMD_ID: enter_mode(flag ? ST_ID_CONFLICT : ST_ID_SETUP);
      CMD_HIT: if (pm_mode == ST_NORMAL || pm_mode == ST_HIT) enter_mode(ST_HIT);
      default: ;
    endcase
    res.state = pm_mode;
    res.effect_set = pm_fx_set;
    res.effect = pm_fx_set ? pm_fx : NO_FX;
    return res;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track_status
    status_t want;
    if (!rst_n) begin
      pm_mode = ST_BOOT;
      pm_dwell = '0;
      pm_link_lost = 1'b0;
      tm_boot = BOOT_TIME_RST;
      tm_hit = HIT_TIME_RST;
      tm_id = ID_SHOW_RST;
      pending_status.delete();
      quiet_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BOOT_TIME: tm_boot = cfg_data;
          REG_HIT_TIME: tm_hit = cfg_data;
          REG_ID_SHOW: tm_id = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = next_status(in_cmd, in_flag, in_fault_present);
        if (in_typed) want = in_exp;
        pending_status.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual state %0d", $time,
                   out_state);
        end else begin
          want = pending_status.pop_front();
          check_field("state", want.state, out_state);
          check_field("effect_set", want.effect_set, out_effect_set);
          check_field("effect", want.effect, out_effect);
        end
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(logic [CmdW-1:0] cmd, logic flag, logic fault, logic typed,
                           status_t exp);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_flag <= flag;
    in_fault_present <= fault;
    in_typed <= typed;
    in_exp <= exp;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every predicted beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [TimeW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TimeW-1:0] pick_timeout();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 85) return TimeW'($urandom_range(12, 1));
    return TimeW'($urandom);
  endfunction

  initial begin : stimulus
    logic [CmdW-1:0] cmd;
    logic flag;
    logic fault;
    int unsigned r;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        drain_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        send_item(DIRECTED[i].cmd, DIRECTED[i].flag, DIRECTED[i].fault, DIRECTED[i].typed,
                  DIRECTED[i].exp);
      end
    end

    // maximum time-outs: hold link-down, then an ID display that never
    // times out within the run
    drain_results();
    write_reg(REG_BOOT_TIME, '1);
    write_reg(REG_HIT_TIME, '1);
    write_reg(REG_ID_SHOW, '1);
    send_item(CMD_COMM, 1'b1, 1'b0, 1'b0, NO_STATUS);
    repeat (8) send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS);
    send_item(CMD_COMM, 1'b0, 1'b0, 1'b0, NO_STATUS);
    send_item(CMD_ID, 1'b0, 1'b0, 1'b0, NO_STATUS);
    repeat (8) send_item(CMD_TICK, 1'b0, 1'b0, 1'b0, NO_STATUS);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_reg(REG_BOOT_TIME, pick_timeout());
      write_reg(REG_HIT_TIME, pick_timeout());
      write_reg(REG_ID_SHOW, pick_timeout());
      src_idle_pct = SRC_IDLE[ph % 4];
      sink_stall_pct = SINK_STALL[ph % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // keep offering beats while the result side holds off
        if (ph % 4 == 0 && n == 60) hold_req <= 1'b1;
        if (ph % 4 == 0 && n == 120) drain_results();
        r = $urandom_range(99);
        flag = 1'($urandom_range(1));
        fault = 1'($urandom_range(1));
        if (r < 70) begin
          cmd = CMD_TICK;
          fault = ($urandom_range(99) < 12);
        end else if (r < 80) begin
          cmd = CMD_COMM;
          flag = ($urandom_range(99) < 35);
        end else if (r < 88) begin
          cmd = CMD_ID;
        end else begin
          cmd = CMD_HIT;
        end
        send_item(cmd, flag, fault, 1'b0, NO_STATUS);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
